### src/lru_page_replacement_macros.svh
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared property shorthands for the checker; clock clk, reset rst.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication
`define LRU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, register codes, scan token and frame write types, controller states.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OCC_W      = $clog2(FRAMES + 1);
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int STEP_W     = $clog2(CNT_W) + 1;
  localparam int PAGE_ID_W  = 16;
  localparam int PERIOD_W   = 16;
  localparam int FIU_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [FIU_W-1:0]    FIU_RESET    = 4'd5;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_IN_USE = 1'b0,
    REG_REPORT_PERIOD = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // Token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic                 go;
    logic [PAGE_BITS-1:0] page;
    logic [STAMP_W-1:0]   stamp;
    logic                 found;
    logic [IDX_W-1:0]     found_idx;
    logic [OCC_W-1:0]     occ;
    logic                 free_v;
    logic [IDX_W-1:0]     free_idx;
    logic                 best_v;
    logic [STAMP_W-1:0]   best_age;
    logic [IDX_W-1:0]     best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } scan_t;

  // Broadcast frame update
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [PAGE_BITS-1:0] page;
    logic [STAMP_W-1:0]   stamp;
  } frame_wr_t;

  // Remainder unit control
  typedef struct packed {
    logic step;
    logic wrap;
    logic start;
  } rem_ctl_t;

  // Effective capacity: zero acts as one, large values clip to FRAMES
  function automatic logic [OCC_W-1:0] capacity(input logic [FIU_W-1:0] fiu);
    logic [OCC_W-1:0] c;
    if (fiu == '0) begin
      c = OCC_W'(1);
    end else if (int'(fiu) > FRAMES) begin
      c = OCC_W'(FRAMES);
    end else begin
      c = OCC_W'(fiu);
    end
    return c;
  endfunction

endpackage

### src/lru_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU request channel
// Valid/ready channel carrying one page reference per transaction.
// ----------------------------------------------------------------------------
interface lru_req_if;
  logic                           valid;
  logic                           ready;
  logic [lru_pkg::PAGE_ID_W-1:0]  page_id;
  logic                           final_reference;

  modport source (output valid, page_id, final_reference, input ready);
  modport sink   (input valid, page_id, final_reference, output ready);
endinterface

### src/lru_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU result channel
// Valid/ready channel carrying one lookup result per transaction.
// ----------------------------------------------------------------------------
interface lru_res_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic                           evict_valid;
  logic [lru_pkg::PAGE_ID_W-1:0]  evicted_page;
  logic [lru_pkg::CNT_W-1:0]      hit_total;
  logic [lru_pkg::CNT_W-1:0]      miss_total;
  logic                           report_point;
  logic                           run_end;

  modport source (output valid, hit, evict_valid, evicted_page, hit_total, miss_total,
                  report_point, run_end, input ready);
  modport sink   (input valid, hit, evict_valid, evicted_page, hit_total, miss_total,
                  report_point, run_end, output ready);
endinterface

### src/lru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one page frame and folds it into the scan token passing through.
// ----------------------------------------------------------------------------
module lru_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lru_pkg::IDX_W-1:0]     cell_idx,
  input  lru_pkg::scan_t                tok_in,
  output lru_pkg::scan_t                tok_out,
  input  lru_pkg::frame_wr_t            wr
);

  logic                          valid;
  logic [lru_pkg::PAGE_BITS-1:0] page;
  logic [lru_pkg::STAMP_W-1:0]   stamp;
  logic [lru_pkg::STAMP_W-1:0]   age;
  logic                          match;
  lru_pkg::scan_t                tok_next;

  // Merge this frame into the token
  always_comb begin
    age      = tok_in.stamp - stamp;
    match    = valid && (page == tok_in.page);
    tok_next = tok_in;
    if (valid) begin
      tok_next.occ = tok_in.occ + lru_pkg::OCC_W'(1);
      if (!tok_in.found && match) begin
        tok_next.found     = 1'b1;
        tok_next.found_idx = cell_idx;
      end
      if (!tok_in.best_v || (age > tok_in.best_age)) begin
        tok_next.best_v    = 1'b1;
        tok_next.best_age  = age;
        tok_next.best_idx  = cell_idx;
        tok_next.best_page = page;
      end
    end else if (!tok_in.free_v) begin
      tok_next.free_v   = 1'b1;
      tok_next.free_idx = cell_idx;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Take a frame update addressed to this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && (wr.idx == cell_idx)) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      page  <= wr.page;
      stamp <= wr.stamp;
    end
  end

endmodule

### src/lru_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU report remainder
// Tracks reference count modulo report period; rebuilds it bit-serially
// after a period write.
// ----------------------------------------------------------------------------
module lru_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  lru_pkg::rem_ctl_t             ctl,
  input  logic [lru_pkg::CNT_W-1:0]     count,
  input  logic [lru_pkg::PERIOD_W-1:0]  period,
  output logic                          busy,
  output logic                          step_zero
);

  logic [lru_pkg::PERIOD_W-1:0] rem;
  logic [lru_pkg::CNT_W-1:0]    dividend;
  logic [lru_pkg::STEP_W-1:0]   step_cnt;
  logic [lru_pkg::PERIOD_W:0]   rem_inc;
  logic [lru_pkg::PERIOD_W:0]   trial;
  logic [lru_pkg::PERIOD_W:0]   trial_red;

  // Remainder after one more reference
  always_comb begin
    rem_inc   = {1'b0, rem} + (lru_pkg::PERIOD_W + 1)'(1);
    step_zero = ctl.wrap || (rem_inc == {1'b0, period});
  end

  // One restoring step per cycle
  always_comb begin
    trial     = {rem, dividend[lru_pkg::CNT_W-1]};
    trial_red = (trial >= {1'b0, period}) ? (trial - {1'b0, period}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rem      <= '0;
      step_cnt <= '0;
    end else if (ctl.start) begin
      busy     <= 1'b1;
      rem      <= '0;
      step_cnt <= '0;
    end else if (busy) begin
      rem      <= trial_red[lru_pkg::PERIOD_W-1:0];
      step_cnt <= step_cnt + lru_pkg::STEP_W'(1);
      if (step_cnt == lru_pkg::STEP_W'(lru_pkg::CNT_W - 1)) begin
        busy <= 1'b0;
      end
    end else if (ctl.step) begin
      rem <= step_zero ? '0 : rem_inc[lru_pkg::PERIOD_W-1:0];
    end
  end

  // Shift the dividend out MSB first
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dividend <= count;
    end else if (busy) begin
      dividend <= {dividend[lru_pkg::CNT_W-2:0], 1'b0};
    end
  end

endmodule

### src/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative least-recently-used page frame manager.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one page reference per transaction; res returns one result
//   per reference in order: hit, eviction, running totals, report flag and
//   the echoed end-of-run marker. cfg_we/cfg_idx/cfg_data write the capacity
//   (index 0) and the report period (index 1).
// Timing:
//   A scan token walks the row of FRAMES frame cells, one cell per cycle; the
//   scan result is then registered and the decide state resolves the hit or
//   the victim into the output register. A new reference is taken only once
//   the previous one has been resolved.
//   A report period write rebuilds the reference count remainder one bit per
//   cycle, holding req.ready low until the rebuild is done.
// Reset: all frames empty, counters zero, capacity 5, report period 25.
// Stall: the result sits in an output register; the next reference is still
//   accepted and scanned, and resolves once the register is taken.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lru_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lru_pkg::CFG_DATA_W-1:0]  cfg_data,
  lru_req_if.sink                         req,
  lru_res_if.source                       res
);

  lru_pkg::state_t               state;
  lru_pkg::state_t               state_next;
  logic [lru_pkg::FIU_W-1:0]     fiu;
  logic [lru_pkg::PERIOD_W-1:0]  period;
  logic [lru_pkg::CNT_W-1:0]     count;
  logic [lru_pkg::CNT_W-1:0]     count_next;
  logic [lru_pkg::CNT_W-1:0]     hit_cnt;
  logic [lru_pkg::CNT_W-1:0]     miss_cnt;
  logic                          fin;
  logic                          report;
  lru_pkg::scan_t                scan;
  lru_pkg::scan_t                tok [lru_pkg::FRAMES+1];
  lru_pkg::frame_wr_t            wr;
  lru_pkg::rem_ctl_t             rem_ctl;
  logic                          rem_busy;
  logic                          step_zero;
  logic                          period_wr;
  logic                          accept;
  logic                          out_free;
  logic                          in_ready;
  logic                          latch_scan;
  logic                          commit;
  logic                          is_hit;
  logic                          evict;
  logic [lru_pkg::IDX_W-1:0]     slot;
  logic                          out_valid;
  logic                          out_hit;
  logic                          out_evict;
  logic [lru_pkg::PAGE_ID_W-1:0] out_evicted;
  logic                          out_report;
  logic                          out_fin;

  assign period_wr  = cfg_we && (lru_pkg::cfg_reg_t'(cfg_idx) == lru_pkg::REG_REPORT_PERIOD);
  assign accept     = req.valid && req.ready;
  assign count_next = count + lru_pkg::CNT_W'(1);
  assign out_free   = !out_valid || res.ready;
  assign req.ready  = in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fiu    <= lru_pkg::FIU_RESET;
      period <= lru_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (lru_pkg::cfg_reg_t'(cfg_idx))
        lru_pkg::REG_FRAMES_IN_USE: fiu    <= cfg_data[lru_pkg::FIU_W-1:0];
        lru_pkg::REG_REPORT_PERIOD: period <= cfg_data[lru_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller next state
  always_comb begin
    state_next = state;
    unique case (state)
      lru_pkg::ST_IDLE:   if (accept) state_next = lru_pkg::ST_SCAN;
      lru_pkg::ST_SCAN:   if (tok[lru_pkg::FRAMES].go) state_next = lru_pkg::ST_DECIDE;
      lru_pkg::ST_DECIDE: if (out_free) state_next = lru_pkg::ST_IDLE;
      default:            state_next = lru_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready   = 1'b0;
    latch_scan = 1'b0;
    commit     = 1'b0;
    unique case (state)
      lru_pkg::ST_IDLE:   in_ready   = !rem_busy && !period_wr;
      lru_pkg::ST_SCAN:   latch_scan = tok[lru_pkg::FRAMES].go;
      lru_pkg::ST_DECIDE: commit     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Launch the scan token with the new reference
  always_comb begin
    tok[0]       = '0;
    tok[0].go    = accept;
    tok[0].page  = lru_pkg::PAGE_BITS'(req.page_id);
    tok[0].stamp = count_next;
  end

  // Row of frame cells
  for (genvar k = 0; k < lru_pkg::FRAMES; k++) begin : g_cell
    lru_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (lru_pkg::IDX_W'(k)),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1]),
      .wr       (wr)
    );
  end

  // Reference count remainder for report points
  assign rem_ctl.step  = accept;
  assign rem_ctl.wrap  = (count_next == '0);
  assign rem_ctl.start = period_wr;

  lru_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rem_ctl),
    .count     (count),
    .period    (period),
    .busy      (rem_busy),
    .step_zero (step_zero)
  );

  // Count references and hold per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fin    <= req.final_reference;
      report <= (period != '0) && step_zero;
    end
    if (latch_scan) begin
      scan <= tok[lru_pkg::FRAMES];
    end
  end

  // Resolve hit, free frame or victim
  always_comb begin
    is_hit = scan.found;
    evict  = 1'b0;
    slot   = '0;
    if (is_hit) begin
      slot = scan.found_idx;
    end else if ((scan.occ < lru_pkg::capacity(fiu)) && scan.free_v) begin
      slot = scan.free_idx;
    end else if (scan.best_v) begin
      slot  = scan.best_idx;
      evict = 1'b1;
    end
    wr.en    = commit;
    wr.idx   = slot;
    wr.page  = scan.page;
    wr.stamp = scan.stamp;
  end

  // Saturating hit and miss counters
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt  <= '0;
      miss_cnt <= '0;
    end else if (commit) begin
      if (is_hit && (hit_cnt != '1)) begin
        hit_cnt <= hit_cnt + lru_pkg::CNT_W'(1);
      end
      if (!is_hit && (miss_cnt != '1)) begin
        miss_cnt <= miss_cnt + lru_pkg::CNT_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit     <= is_hit;
      out_evict   <= evict;
      out_evicted <= evict ? lru_pkg::PAGE_ID_W'(scan.best_page) : '0;
      out_report  <= report;
      out_fin     <= fin;
    end
  end

  assign res.valid        = out_valid;
  assign res.hit          = out_hit;
  assign res.evict_valid  = out_evict;
  assign res.evicted_page = out_evicted;
  assign res.hit_total    = hit_cnt;
  assign res.miss_total   = miss_cnt;
  assign res.report_point = out_report;
  assign res.run_end      = out_fin;

endmodule

### src/lru_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level checks on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lru_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           hit,
  input logic                           evict_valid,
  input logic [lru_pkg::PAGE_ID_W-1:0]  evicted_page
);

  // A hit never replaces a page
  `LRU_ASSERT_SAME(a_hit_no_evict, out_valid && hit, !evict_valid, "eviction on a hit")

  // No eviction means the evicted page reads zero
  `LRU_ASSERT_SAME(a_evict_zero, out_valid && !evict_valid, evicted_page == '0,
                   "evicted page nonzero without eviction")

  // One reference in flight: no acceptance in the cycle after one
  `LRU_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
                   "back-to-back request acceptance")

  // A stalled result holds
  `LRU_ASSERT_NEXT(a_res_hold, out_valid && !out_ready,
                   out_valid && $stable(hit) && $stable(evict_valid) && $stable(evicted_page),
                   "stalled result changed")

endmodule

bind lru_page_replacement lru_chk u_lru_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .hit          (res.hit),
  .evict_valid  (res.evict_valid),
  .evicted_page (res.evicted_page)
);

### tb/sv/lru_page_replacement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page references through the request channel and checks every
// lookup result against an in-bench LRU frame table: hit, victim, running
// totals, report flag and end marker. A short directed table covers the
// extremes, capacity clipping, capacity lowered below occupancy and report
// periods of zero, one and the maximum. Random phases then replay small page
// working sets under several capacity and period settings, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
  import lru_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_MAX    = 12;

  typedef struct packed {
    logic                 hit;
    logic                 evict_valid;
    logic [PAGE_ID_W-1:0] evicted_page;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
    logic                 report_point;
    logic                 run_end;
  } lru_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cfg_reg_t              sel;
    logic [CFG_DATA_W-1:0] data;
    logic [PAGE_ID_W-1:0]  page;
    logic                  fin;
    logic                  known;
    lru_result_t           result;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lru_req_if req_ch ();
  lru_res_if res_ch ();

  lru_page_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .res      (res_ch)
  );

  // Frame table mirror and register copies
  logic [PAGE_ID_W-1:0] frame_page_m  [FRAMES];
  logic                 frame_valid_m [FRAMES];
  logic [STAMP_W-1:0]   frame_stamp_m [FRAMES];
  logic [STAMP_W-1:0]   ref_count;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;
  logic [FIU_W-1:0]     capacity_reg;
  logic [PERIOD_W-1:0]  period_reg;

  lru_result_t pending_results[$];
  stim_row_t   stimulus_rows[$];
  int          mismatch_count;
  int          cycle_count;
  int          quiet_left;
  bit          idling_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Resolve one reference against the frame table and return its result
  function automatic lru_result_t predict_reference(input logic [PAGE_ID_W-1:0] page,
                                                     input logic fin);
    lru_result_t r;
    int found;
    int slot;
    int occupied;
    int cap;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] oldest_age;
    r = '0;
    found = -1;
    slot = -1;
    occupied = 0;
    oldest_age = '0;
    ref_count = ref_count + 1;
    if (capacity_reg == '0) begin
      cap = 1;
    end else if (int'(capacity_reg) > FRAMES) begin
      cap = FRAMES;
    end else begin
      cap = int'(capacity_reg);
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (frame_valid_m[i]) begin
        occupied++;
        if (found < 0 && frame_page_m[i] == page) found = i;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      frame_stamp_m[found] = ref_count;
      if (hit_count != '1) hit_count = hit_count + 1;
    end else begin
      // take the lowest free frame while under capacity
      if (occupied < cap) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (!frame_valid_m[i] && slot < 0) slot = i;
        end
      end
      // otherwise replace the oldest resident page, lowest frame on a tie
      if (slot < 0) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_valid_m[i]) begin
            age = ref_count - frame_stamp_m[i];
            if (slot < 0 || age > oldest_age) begin
              slot = i;
              oldest_age = age;
            end
          end
        end
        if (slot >= 0) begin
          r.evict_valid = 1'b1;
          r.evicted_page = frame_page_m[slot];
        end else begin
          slot = 0;
        end
      end
      frame_page_m[slot]  = page;
      frame_valid_m[slot] = 1'b1;
      frame_stamp_m[slot] = ref_count;
      if (miss_count != '1) miss_count = miss_count + 1;
    end
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    r.report_point = (period_reg != '0) && ((ref_count % period_reg) == 0);
    r.run_end = fin;
    return r;
  endfunction

  function automatic lru_result_t make_result(input logic h, input logic ev,
                                              input logic [PAGE_ID_W-1:0] evp,
                                              input logic [CNT_W-1:0] ht,
                                              input logic [CNT_W-1:0] mt,
                                              input logic rp, input logic re);
    lru_result_t r;
    r.hit = h;
    r.evict_valid = ev;
    r.evicted_page = evp;
    r.hit_total = ht;
    r.miss_total = mt;
    r.report_point = rp;
    r.run_end = re;
    return r;
  endfunction

  function automatic void add_ref(input logic [PAGE_ID_W-1:0] page, input logic fin);
    stim_row_t row;
    row = '{ROW_REF, REG_FRAMES_IN_USE, '0, page, fin, 1'b0, '0};
    stimulus_rows = {stimulus_rows, row};
  endfunction

  function automatic void add_known(input logic [PAGE_ID_W-1:0] page, input logic fin,
                                    input lru_result_t result);
    stim_row_t row;
    row = '{ROW_REF, REG_FRAMES_IN_USE, '0, page, fin, 1'b1, result};
    stimulus_rows = {stimulus_rows, row};
  endfunction

  function automatic void add_cfg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{ROW_CFG, sel, data, '0, 1'b0, 1'b0, '0};
    stimulus_rows = {stimulus_rows, row};
  endfunction

  // Drop valid and hold until every outstanding result has been taken
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write one register once the block is idle
  task automatic write_register(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (FRAMES + 2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (sel == REG_FRAMES_IN_USE) begin
      capacity_reg = data[FIU_W-1:0];
    end else begin
      period_reg = data[PERIOD_W-1:0];
    end
  endtask

  // Insert a random sender gap, with quiet stretches in between
  task automatic maybe_pause();
    if (idling_on) begin
      if (quiet_left > 0) begin
        quiet_left--;
      end else if ($urandom_range(0, 24) == 0) begin
        quiet_left = $urandom_range(10, 30);
      end else if ($urandom_range(0, 3) == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  // Present one reference and record its expected result on acceptance
  task automatic send_reference(input logic [PAGE_ID_W-1:0] page, input logic fin,
                                input logic known, input lru_result_t typed);
    lru_result_t predicted;
    req_ch.valid           <= 1'b1;
    req_ch.page_id         <= page;
    req_ch.final_reference <= fin;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_reference(page, fin);
    if (known) predicted = typed;
    pending_results = {pending_results, predicted};
  endtask

  // Result receiver: random ready bursts while idling is on
  initial begin : result_sink
    int hold;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        hold = $urandom_range(1, 7);
      end else begin
        res_ch.ready <= 1'b1;
        hold = $urandom_range(1, 24);
      end
      repeat (hold) @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    lru_result_t seen;
    lru_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen = make_result(res_ch.hit, res_ch.evict_valid, res_ch.evicted_page,
                         res_ch.hit_total, res_ch.miss_total, res_ch.report_point,
                         res_ch.run_end);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] result with nothing expected: hit=%0b ev=%0b page=%h", $realtime,
                   seen.hit, seen.evict_valid, seen.evicted_page);
        end
      end else begin
        want = pending_results.pop_front();
        if (seen.hit !== want.hit || seen.evict_valid !== want.evict_valid ||
            seen.evicted_page !== want.evicted_page || seen.hit_total !== want.hit_total ||
            seen.miss_total !== want.miss_total || seen.report_point !== want.report_point ||
            seen.run_end !== want.run_end) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] mismatch exp: hit=%0b ev=%0b page=%h hits=%0d misses=%0d rp=%0b end=%0b",
                     $realtime, want.hit, want.evict_valid, want.evicted_page,
                     want.hit_total, want.miss_total, want.report_point, want.run_end);
            $display("            got: hit=%0b ev=%0b page=%h hits=%0d misses=%0d rp=%0b end=%0b",
                     seen.hit, seen.evict_valid, seen.evicted_page,
                     seen.hit_total, seen.miss_total, seen.report_point, seen.run_end);
          end
        end
      end
    end
  end

  // Timeout
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lru_page_replacement_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [PAGE_ID_W-1:0] pool [POOL_MAX];
    logic [PAGE_ID_W-1:0] page;
    logic [FIU_W-1:0]     fiu;
    logic [PERIOD_W-1:0]  period;
    int pool_size;
    int eff;
    int count;
    int pick;

    // known values on every input from time zero
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_idx                <= REG_FRAMES_IN_USE;
    cfg_data               <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.page_id         <= '0;
    req_ch.final_reference <= 1'b0;
    idling_on      = 1'b1;
    quiet_left     = 0;
    mismatch_count = 0;

    // mirror the reset state
    for (int i = 0; i < FRAMES; i++) begin
      frame_valid_m[i] = 1'b0;
      frame_page_m[i]  = '0;
      frame_stamp_m[i] = '0;
    end
    ref_count    = '0;
    hit_count    = '0;
    miss_count   = '0;
    capacity_reg = FIU_RESET;
    period_reg   = PERIOD_RESET;

    // directed table: reset defaults, extremes, capacity and period corners
    add_known(16'h0000, 1'b0, make_result(1'b0, 1'b0, 16'h0000, 32'd0, 32'd1, 1'b0, 1'b0));
    add_known(16'hFFFF, 1'b1, make_result(1'b0, 1'b0, 16'h0000, 32'd0, 32'd2, 1'b0, 1'b1));
    add_known(16'h0000, 1'b0, make_result(1'b1, 1'b0, 16'h0000, 32'd1, 32'd2, 1'b0, 1'b0));
    add_ref(16'hFFFF, 1'b0);
    add_ref(16'h0001, 1'b0);
    add_ref(16'h0002, 1'b0);
    add_ref(16'h0003, 1'b0);
    // table full: page 0 is the oldest resident
    add_known(16'h0004, 1'b0, make_result(1'b0, 1'b1, 16'h0000, 32'd2, 32'd6, 1'b0, 1'b0));
    add_ref(16'h0000, 1'b0);
    // capacity lowered below occupancy
    add_cfg(REG_FRAMES_IN_USE, 16'd2);
    add_ref(16'h0001, 1'b0);
    add_ref(16'h0005, 1'b0);
    add_ref(16'h0006, 1'b1);
    // capacity zero acts as one
    add_cfg(REG_FRAMES_IN_USE, 16'd0);
    add_ref(16'h0007, 1'b0);
    add_cfg(REG_REPORT_PERIOD, 16'd1);
    add_ref(16'h0007, 1'b0);
    add_ref(16'hAAAA, 1'b0);
    // report period zero never flags
    add_cfg(REG_REPORT_PERIOD, 16'd0);
    add_ref(16'h5555, 1'b0);
    // capacity above the frame count clips to it
    add_cfg(REG_FRAMES_IN_USE, 16'd15);
    add_ref(16'h8000, 1'b0);
    add_ref(16'h1234, 1'b0);
    add_ref(16'h4321, 1'b0);
    add_ref(16'h7FFF, 1'b0);
    // upper data bits are ignored for the capacity register
    add_cfg(REG_FRAMES_IN_USE, 16'hFFF8);
    add_cfg(REG_REPORT_PERIOD, 16'hFFFF);
    add_ref(16'h0000, 1'b1);
    add_ref(16'hFFFE, 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    foreach (stimulus_rows[n]) begin
      if (stimulus_rows[n].kind == ROW_CFG) begin
        write_register(stimulus_rows[n].sel, stimulus_rows[n].data);
      end else begin
        maybe_pause();
        send_reference(stimulus_rows[n].page, stimulus_rows[n].fin,
                       stimulus_rows[n].known, stimulus_rows[n].result);
      end
    end

    // random phases over small working sets, last one without idling
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          fiu = 4'd3;
          period = 16'd7;
        end
        1: begin
          fiu = 4'd8;
          period = 16'hFFFF;
        end
        2: begin
          fiu = 4'd1;
          period = 16'd1;
        end
        3: begin
          fiu = 4'($urandom_range(0, 15));
          period = 16'd0;
        end
        4: begin
          fiu = 4'($urandom_range(1, 8));
          period = 16'($urandom_range(2, 40));
        end
        5: begin
          fiu = 4'($urandom_range(9, 15));
          period = 16'd25;
        end
        default: begin
          fiu = 4'd5;
          period = 16'($urandom_range(1, 16));
        end
      endcase
      write_register(REG_FRAMES_IN_USE, {12'($urandom), fiu});
      write_register(REG_REPORT_PERIOD, period);
      if (ph == 6) idling_on = 1'b0;

      eff = (fiu == 0) ? 1 : ((int'(fiu) > FRAMES) ? FRAMES : int'(fiu));
      pool_size = eff + $urandom_range(1, 4);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      for (int k = 0; k < POOL_MAX; k++) pool[k] = 16'($urandom);
      count = (ph == 6) ? 150 : 197;

      for (int n = 0; n < count; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          page = pool[$urandom_range(0, pool_size - 1)];
        end else if (pick < 90) begin
          page = 16'($urandom);
        end else if (pick < 95) begin
          // near miss: one bit away from a resident candidate
          page = pool[$urandom_range(0, pool_size - 1)] ^ (16'd1 << $urandom_range(0, 15));
        end else begin
          page = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        // occasionally hold off until the pipeline is empty
        if (idling_on && $urandom_range(0, 99) == 0) wait_drained();
        maybe_pause();
        send_reference(page, ($urandom_range(0, 15) == 0), 1'b0, '0);
      end
    end

    // drain and let the block settle
    wait_drained();
    repeat (FRAMES + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("lru_page_replacement_tb: done, clean");
    end else begin
      $display("lru_page_replacement_tb: done, errors");
    end
    $finish;
  end

endmodule

### lru_page_replacement.f
+incdir+src
src/lru_pkg.sv
src/lru_req_if.sv
src/lru_res_if.sv
src/lru_cell.sv
src/lru_rem.sv
src/lru_page_replacement.sv
src/lru_chk.sv
tb/sv/lru_page_replacement_tb.sv
